// ===== sv/pwcc_pkg.sv =====
// shared types, register indexes and reset values of the pulse width channel classifier
package pwcc_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;
   localparam int CFG_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 3;
   localparam int RSP_DEPTH          = 4;

   localparam logic [CFG_BITS-1:0] WIDTH_ONE_RESET   = 16'd189;
   localparam logic [CFG_BITS-1:0] WIDTH_TWO_RESET   = 16'd186;
   localparam logic [CFG_BITS-1:0] WIDTH_THREE_RESET = 16'd183;
   localparam logic [CFG_BITS-1:0] WIDTH_FOUR_RESET  = 16'd179;
   localparam logic [CFG_BITS-1:0] REPEAT_RESET      = 16'd10000;

   localparam logic [2:0] CHAN_NONE  = 3'd0;
   localparam logic [2:0] CHAN_ONE   = 3'd1;
   localparam logic [2:0] CHAN_TWO   = 3'd2;
   localparam logic [2:0] CHAN_THREE = 3'd3;
   localparam logic [2:0] CHAN_FOUR  = 3'd4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WIDTH_ONE   = 3'd0,
      CSR_WIDTH_TWO   = 3'd1,
      CSR_WIDTH_THREE = 3'd2,
      CSR_WIDTH_FOUR  = 3'd3,
      CSR_REPEAT      = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      EVT_CHANGE  = 2'd0,
      EVT_REPEAT  = 2'd1,
      EVT_NOMATCH = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] width_one;
      logic [CFG_BITS-1:0] width_two;
      logic [CFG_BITS-1:0] width_three;
      logic [CFG_BITS-1:0] width_four;
      logic [CFG_BITS-1:0] repeat_interval;
   } cfg_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [2:0]     channel;
      logic           last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== sv/pwcc_csr.sv =====
// configuration registers of the pulse width channel classifier
module pwcc_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pwcc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pwcc_pkg::CFG_BITS-1:0]         csr_wdata,
   output pwcc_pkg::cfg_type                     cfg
);
   import pwcc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WIDTH_ONE:   cfg_in.width_one       = csr_wdata;
            CSR_WIDTH_TWO:   cfg_in.width_two       = csr_wdata;
            CSR_WIDTH_THREE: cfg_in.width_three     = csr_wdata;
            CSR_WIDTH_FOUR:  cfg_in.width_four      = csr_wdata;
            CSR_REPEAT:      cfg_in.repeat_interval = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width_one       <= WIDTH_ONE_RESET;
         cfg_ff.width_two       <= WIDTH_TWO_RESET;
         cfg_ff.width_three     <= WIDTH_THREE_RESET;
         cfg_ff.width_four      <= WIDTH_FOUR_RESET;
         cfg_ff.repeat_interval <= REPEAT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/pwcc_core.sv =====
// pulse counting, width classification and report decision
module pwcc_core #(
   parameter int COUNT_BITS = pwcc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              line_level,
   input  pwcc_pkg::cfg_type cfg,
   output pwcc_pkg::push_type push
);
   import pwcc_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;

   logic                  in_pulse_ff, in_pulse_in;
   logic [COUNT_BITS-1:0] pulse_ticks_ff, pulse_ticks_in;
   logic [COUNT_BITS-1:0] since_ff, since_in;
   logic [2:0]            cur_chan_ff, cur_chan_in;
   logic [2:0]            rep_chan_ff, rep_chan_in;

   logic [COUNT_BITS-1:0] pulse_inc;
   logic [COUNT_BITS-1:0] since_inc;
   logic [CMP_BITS-1:0]   width;
   logic                  falling;
   logic                  nomatch;
   logic                  changed;
   logic                  repeated;
   logic [2:0]            chan_next;
   result_type            chan_rsp;

   assign pulse_inc = (pulse_ticks_ff == '1) ? pulse_ticks_ff : pulse_ticks_ff + 1'b1;
   assign since_inc = (since_ff == '1) ? since_ff : since_ff + 1'b1;
   assign width     = CMP_BITS'(pulse_ticks_ff);
   assign falling   = !line_level && in_pulse_ff;

   always_comb begin
      nomatch = 1'b0;
      if (width >= CMP_BITS'(cfg.width_one)) begin
         chan_next = CHAN_ONE;
      end else if (width >= CMP_BITS'(cfg.width_two)) begin
         chan_next = CHAN_TWO;
      end else if (width >= CMP_BITS'(cfg.width_three)) begin
         chan_next = CHAN_THREE;
      end else if (width >= CMP_BITS'(cfg.width_four)) begin
         chan_next = CHAN_FOUR;
      end else begin
         chan_next = cur_chan_ff;
         nomatch   = 1'b1;
      end
   end

   assign changed  = chan_next != rep_chan_ff;
   assign repeated = !changed &&
                     (CMP_BITS'(since_inc) > CMP_BITS'(cfg.repeat_interval));

   always_comb begin
      chan_rsp.event_kind  = changed ? EVT_CHANGE : EVT_REPEAT;
      chan_rsp.channel     = chan_next;
      chan_rsp.last_of_run = 1'b1;

      push.count  = 2'd0;
      push.first  = chan_rsp;
      push.second = chan_rsp;
      if (accept && falling) begin
         if (nomatch) begin
            push.first.event_kind  = EVT_NOMATCH;
            push.first.channel     = cur_chan_ff;
            push.first.last_of_run = !(changed || repeated);
            push.count             = (changed || repeated) ? 2'd2 : 2'd1;
         end else begin
            push.count = (changed || repeated) ? 2'd1 : 2'd0;
         end
      end
   end

   always_comb begin
      in_pulse_in    = in_pulse_ff;
      pulse_ticks_in = pulse_ticks_ff;
      since_in       = since_ff;
      cur_chan_in    = cur_chan_ff;
      rep_chan_in    = rep_chan_ff;
      if (accept) begin
         since_in = since_inc;
         if (line_level) begin
            in_pulse_in    = 1'b1;
            pulse_ticks_in = pulse_inc;
         end else if (in_pulse_ff) begin
            in_pulse_in    = 1'b0;
            pulse_ticks_in = '0;
            cur_chan_in    = chan_next;
            if (changed) begin
               rep_chan_in = chan_next;
               since_in    = '0;
            end else if (repeated) begin
               since_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_pulse_ff    <= 1'b0;
         pulse_ticks_ff <= '0;
         since_ff       <= '0;
         cur_chan_ff    <= CHAN_NONE;
         rep_chan_ff    <= CHAN_NONE;
      end else begin
         in_pulse_ff    <= in_pulse_in;
         pulse_ticks_ff <= pulse_ticks_in;
         since_ff       <= since_in;
         cur_chan_ff    <= cur_chan_in;
         rep_chan_ff    <= rep_chan_in;
      end
   end

`ifndef SYNTHESIS
   // two results only when the width matched no channel
   assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.event_kind == EVT_NOMATCH)
      else $error("pwcc_core: two results without a nomatch");

   // results come only from a falling edge
   assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> accept && !line_level && in_pulse_ff)
      else $error("pwcc_core: result outside a falling edge");

   // after a falling edge the reported channel follows the current one
   assert property (@(posedge clock) disable iff (reset)
      accept && falling |=> cur_chan_ff == rep_chan_ff)
      else $error("pwcc_core: reported channel lags current channel");
`endif

endmodule

// ===== sv/pwcc_fifo.sv =====
// result queue between the classifier and the result channel
module pwcc_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  pwcc_pkg::push_type     push,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pwcc_pkg::result_type   rsp
);
   import pwcc_pkg::*;

   localparam int PTR_BITS = $clog2(RSP_DEPTH);
   localparam int CNT_BITS = $clog2(RSP_DEPTH + 1);

   result_type            mem_ff [RSP_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [PTR_BITS-1:0]   wr_next;
   logic                  pop;

   assign rsp_valid = count_ff != '0;
   assign rsp       = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for two results is kept for the next beat
   assign full      = count_ff > CNT_BITS'(RSP_DEPTH - 2);
   assign wr_next   = wr_ptr_ff + PTR_BITS'(1);

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
   assign rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
   assign count_in  = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(RSP_DEPTH))
      else $error("pwcc_fifo: count above depth");

   // pushes never land while the queue is marked full
   assert property (@(posedge clock) disable iff (reset)
      full |-> push.count == 2'd0 || pop)
      else $error("pwcc_fifo: push into full queue");

   assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == PTR_BITS'(count_ff))
      else $error("pwcc_fifo: pointers disagree with count");
`endif

endmodule

// ===== sv/pulse_width_channel_classifier.sv =====
// top level of the pulse width channel classifier
//
// req channel: one beat per line sample (req_line_level), valid/stall.
// rsp channel: result beats (rsp_event_kind, rsp_channel, rsp_last_of_run),
//   valid/stall; a falling edge of the line gives zero, one or two beats,
//   the last of them flagged by rsp_last_of_run.
// csr channel: valid/ready write of csr_wdata to register csr_index;
//   csr_ready is always high, indexes above four are dropped.
// throughput: one sample per cycle while req_stall is low; the counters
//   and the threshold compare are settled in the cycle the sample is taken.
// results: a sample's results are written into a four-entry result queue
//   when its beat is taken and leave it in order, the second after the first.
// stall: results wait in the queue; req_stall rises when fewer than two
//   entries are free, so no result is ever dropped.
// reset: synchronous; clears counters and channels, queue empty, registers
//   back to their default thresholds and repeat interval.
module pulse_width_channel_classifier #(
   parameter int COUNT_BITS = pwcc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_line_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_event_kind,
   output logic [2:0]                          rsp_channel,
   output logic                                rsp_last_of_run,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pwcc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pwcc_pkg::CFG_BITS-1:0]       csr_wdata
);
   import pwcc_pkg::*;

   cfg_type    cfg;
   push_type   push;
   result_type rsp;
   logic       full;
   logic       accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   pwcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pwcc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .line_level (req_line_level),
      .cfg        (cfg),
      .push       (push)
   );

   pwcc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_event_kind  = rsp.event_kind;
   assign rsp_channel     = rsp.channel;
   assign rsp_last_of_run = rsp.last_of_run;

endmodule

// ===== tb/sv/pwcc_scoreboard_pkg.sv =====
// scoreboard that predicts and checks the result beats of the pulse width channel classifier
package pwcc_tb_pkg;
   import pwcc_pkg::*;

   class pulse_event_scoreboard;
      logic [CFG_BITS-1:0]           min_width[4];
      logic [CFG_BITS-1:0]           repeat_ticks;
      bit                            in_pulse;
      logic [COUNT_BITS_DEFAULT-1:0] pulse_ticks;
      logic [COUNT_BITS_DEFAULT-1:0] ticks_since_report;
      logic [2:0]                    current_chan;
      logic [2:0]                    reported_chan;
      result_type                    pending_events[$];
      int                            errors;

      function new();
         min_width = '{WIDTH_ONE_RESET, WIDTH_TWO_RESET, WIDTH_THREE_RESET, WIDTH_FOUR_RESET};
         repeat_ticks = REPEAT_RESET;
         in_pulse = 0;
         pulse_ticks = '0;
         ticks_since_report = '0;
         current_chan = CHAN_NONE;
         reported_chan = CHAN_NONE;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] index, logic [CFG_BITS-1:0] value);
         case (index)
            CSR_WIDTH_ONE:   min_width[0] = value;
            CSR_WIDTH_TWO:   min_width[1] = value;
            CSR_WIDTH_THREE: min_width[2] = value;
            CSR_WIDTH_FOUR:  min_width[3] = value;
            CSR_REPEAT:      repeat_ticks = value;
            default: ;
         endcase
      endfunction

      function logic [COUNT_BITS_DEFAULT-1:0] sat_bump(logic [COUNT_BITS_DEFAULT-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function result_type make_beat(event_kind_type kind, logic [2:0] chan);
         result_type beat;
         beat.event_kind = kind;
         beat.channel = chan;
         beat.last_of_run = 1'b0;
         return beat;
      endfunction

      function void note_sample(bit level);
         result_type                    run[$];
         logic [COUNT_BITS_DEFAULT-1:0] width;
         bit                            matched;
         ticks_since_report = sat_bump(ticks_since_report);
         if (level) begin
            in_pulse = 1;
            pulse_ticks = sat_bump(pulse_ticks);
         end else if (in_pulse) begin
            width = pulse_ticks;
            in_pulse = 0;
            pulse_ticks = '0;
            matched = 0;
            for (int i = 0; i < 4; i++) begin
               if (!matched && width >= min_width[i]) begin
                  current_chan = CHAN_ONE + 3'(i);
                  matched = 1;
               end
            end
            if (!matched)
               run.push_back(make_beat(EVT_NOMATCH, current_chan));
            if (current_chan != reported_chan) begin
               run.push_back(make_beat(EVT_CHANGE, current_chan));
               reported_chan = current_chan;
               ticks_since_report = '0;
            end else if (ticks_since_report > repeat_ticks) begin
               run.push_back(make_beat(EVT_REPEAT, current_chan));
               ticks_since_report = '0;
            end
            if (run.size() > 0)
               run[run.size()-1].last_of_run = 1'b1;
            foreach (run[i])
               pending_events.push_back(run[i]);
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (pending_events.size() == 0) begin
            $error("unexpected beat: event_kind %0d channel %0d last_of_run %0d",
                   got.event_kind, got.channel, got.last_of_run);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (got.event_kind !== want.event_kind) begin
               $error("event_kind expected %0d actual %0d", want.event_kind, got.event_kind);
               errors++;
            end
            if (got.channel !== want.channel) begin
               $error("channel expected %0d actual %0d", want.channel, got.channel);
               errors++;
            end
            if (got.last_of_run !== want.last_of_run) begin
               $error("last_of_run expected %0d actual %0d", want.last_of_run, got.last_of_run);
               errors++;
            end
         end
      endfunction

      function int waiting();
         return pending_events.size();
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_pulse_width_channel_classifier.sv =====
// testbench top that drives directed and random line samples and register settings into the classifier
module tb_pulse_width_channel_classifier;
   timeunit 1ns;
   timeprecision 1ps;
   import pwcc_pkg::*;
   import pwcc_tb_pkg::*;

   localparam int RANDOM_SAMPLES = 760;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RESULT_DRAIN   = 8;
   localparam int RESET_CYCLES   = 12;
   localparam logic [CFG_BITS-1:0]       CFG_MAX   = '1;
   localparam logic [CSR_INDEX_BITS-1:0] INDEX_MAX = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_line_level;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_event_kind;
   logic [2:0]                rsp_channel;
   logic                      rsp_last_of_run;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CFG_BITS-1:0]       csr_wdata;

   pulse_event_scoreboard classifier_sb;
   logic [CFG_BITS-1:0]   thr[4];
   bit                    sender_quiet;
   bit                    receiver_quiet;
   int                    stall_left;
   int                    stall_pick;
   int                    idle_cycles;
   int                    samples_sent;
   int                    random_first;

   pulse_width_channel_classifier dut (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (receiver_quiet) begin
         rsp_stall = 1'b0;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 55) begin
            rsp_stall = 1'b0;
            stall_left = $urandom_range(0, 5);
         end else if (stall_pick < 88) begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(0, 2);
         end else begin
            rsp_stall = 1'b1;
            stall_left = $urandom_range(8, 40);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         classifier_sb.check_result({event_kind_type'(rsp_event_kind), rsp_channel,
                                     rsp_last_of_run});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   function automatic int sender_gap();
      int pick;
      if (sender_quiet)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 65)
         return 0;
      if (pick < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_sample(input bit level);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_line_level = level;
      do @(posedge clock); while (req_stall);
      classifier_sb.note_sample(level);
      samples_sent++;
      @(negedge clock);
   endtask

   task automatic send_pulse(input int width, input int low);
      repeat (width) send_sample(1'b1);
      repeat (low) send_sample(1'b0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CFG_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      classifier_sb.write_reg(index, data);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [CFG_BITS-1:0] t1, t2, t3, t4, resend_ticks);
      thr = '{t1, t2, t3, t4};
      write_csr(CSR_WIDTH_ONE, t1);
      write_csr(CSR_WIDTH_TWO, t2);
      write_csr(CSR_WIDTH_THREE, t3);
      write_csr(CSR_WIDTH_FOUR, t4);
      write_csr(CSR_REPEAT, resend_ticks);
      // unmapped index, must be dropped
      write_csr(CSR_INDEX_BITS'($urandom_range(CSR_REPEAT + 1, INDEX_MAX)),
                CFG_BITS'($urandom_range(0, CFG_MAX)));
      csr_valid = 1'b0;
      sender_quiet = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (classifier_sb.waiting() != 0) @(negedge clock);
      repeat (RESULT_DRAIN) @(negedge clock);
   endtask

   function automatic int pick_width();
      int base;
      base = int'(thr[$urandom_range(0, 3)]);
      if (base <= 40 && $urandom_range(0, 2) != 0) begin
         base = base + int'($urandom_range(0, 2)) - 1;
         return (base < 1) ? 1 : base;
      end
      return $urandom_range(1, 30);
   endfunction

   task automatic random_setting();
      logic [CFG_BITS-1:0] t1, t2, t3, t4;
      case ($urandom_range(0, 5))
         0: apply_setting(CFG_BITS'($urandom_range(0, CFG_MAX)),
                          CFG_BITS'($urandom_range(0, CFG_MAX)),
                          CFG_BITS'($urandom_range(0, CFG_MAX)),
                          CFG_BITS'($urandom_range(0, CFG_MAX)),
                          CFG_BITS'($urandom_range(0, CFG_MAX)));
         1: apply_setting(CFG_BITS'($urandom_range(0, 24)), CFG_BITS'($urandom_range(0, 24)),
                          CFG_BITS'($urandom_range(0, 24)), CFG_BITS'($urandom_range(0, 24)),
                          CFG_BITS'($urandom_range(0, 80)));
         default: begin
            t4 = CFG_BITS'($urandom_range(0, 8));
            t3 = t4 + CFG_BITS'($urandom_range(0, 5));
            t2 = t3 + CFG_BITS'($urandom_range(0, 5));
            t1 = t2 + CFG_BITS'($urandom_range(0, 5));
            apply_setting(t1, t2, t3, t4, CFG_BITS'($urandom_range(0, 80)));
         end
      endcase
   endtask

   task automatic random_phase(input int length);
      int stop;
      stop = samples_sent + length;
      while (samples_sent < stop) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
         else
            send_pulse(pick_width(), ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                                  : $urandom_range(1, 8));
      end
   endtask

   initial begin
      classifier_sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_line_level = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_WIDTH_ONE;
      csr_wdata = '0;
      stall_left = 0;
      idle_cycles = 0;
      samples_sent = 0;
      sender_quiet = 0;
      receiver_quiet = 0;
      thr = '{WIDTH_ONE_RESET, WIDTH_TWO_RESET, WIDTH_THREE_RESET, WIDTH_FOUR_RESET};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // unmatched width before any channel, with and without a repeat
      send_pulse(1, 2);
      settle();
      apply_setting(WIDTH_ONE_RESET, WIDTH_TWO_RESET, WIDTH_THREE_RESET, WIDTH_FOUR_RESET, '0);
      send_pulse(1, 2);
      settle();

      // default thresholds at their edges
      apply_setting(WIDTH_ONE_RESET, WIDTH_TWO_RESET, WIDTH_THREE_RESET, WIDTH_FOUR_RESET,
                    REPEAT_RESET);
      send_pulse(189, 2);
      send_pulse(185, 2);
      send_pulse(179, 2);
      send_pulse(178, 2);
      settle();

      // zero thresholds and interval, a repeat on every pulse after the change to channel one
      apply_setting('0, '0, '0, '0, '0);
      send_pulse(1, 1);
      send_pulse(1, 1);
      send_pulse(2, 1);
      settle();

      // thresholds out of order
      apply_setting(CFG_MAX, 16'd4, CFG_MAX, '0, 16'd3);
      send_pulse(5, 1);
      send_pulse(1, 1);
      send_pulse(10, 6);
      send_pulse(3, 6);
      settle();

      random_first = samples_sent;
      while (samples_sent - random_first < RANDOM_SAMPLES) begin
         random_setting();
         random_phase($urandom_range(100, 200));
         settle();
      end

      if (classifier_sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== files.f =====
sv/pwcc_pkg.sv
sv/pwcc_csr.sv
sv/pwcc_core.sv
sv/pwcc_fifo.sv
sv/pulse_width_channel_classifier.sv
tb/sv/pwcc_scoreboard_pkg.sv
tb/sv/tb_pulse_width_channel_classifier.sv
